// File: rtl/core/sias_pkg.sv
// Shared constants and types for the stable integer argsort chain.
package sias_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int KEY_WIDTH = 32;
  localparam int FIELD_KEY_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic                        valid;
    logic signed [KEY_WIDTH-1:0] key;
    logic        [POS_W-1:0]     pos;
  } sias_entry_t;

  typedef struct packed {
    logic ins;    // insert the broadcast key into the chain
    logic shift;  // move every entry one cell toward the head
  } sias_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } sias_state_t;

endpackage

// File: rtl/core/sias_cell.sv
// One cell of the insertion chain: holds a single key and its load position.
module sias_cell
  import sias_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sias_ctl_t   ctl,
  input  sias_entry_t new_ent,
  input  sias_entry_t prev_ent,
  input  logic        prev_greater,
  input  sias_entry_t next_ent,
  output sias_entry_t ent,
  output logic        greater
);

  logic                        valid;
  logic signed [KEY_WIDTH-1:0] key;
  logic        [POS_W-1:0]     pos;

  // Empty cells count as larger than any key; ties stay in front (stable).
  assign greater = !valid || ($signed(key) > $signed(new_ent.key));

  assign ent.valid = valid;
  assign ent.key   = key;
  assign ent.pos   = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      if (prev_greater) begin
        valid <= prev_ent.valid;
      end else if (greater) begin
        valid <= 1'b1;
      end
    end else if (ctl.shift) begin
      valid <= next_ent.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_greater) begin
        key <= prev_ent.key;
        pos <= prev_ent.pos;
      end else if (greater) begin
        key <= new_ent.key;
        pos <= new_ent.pos;
      end
    end else if (ctl.shift) begin
      key <= next_ent.key;
      pos <= next_ent.pos;
    end
  end

endmodule

// File: rtl/core/stable_integer_argsort_top.sv
// Stable argsort of signed keys through a chain of MAX_ITEMS insertion cells.
// Load: one key per cycle, inserted into the sorted chain in the cycle it is accepted.
// Drain: first result in the cycle after the request marked tlast is accepted; then one
//   result per cycle while m_tready holds, set by the chain shifting one cell per result.
// No new key is accepted while draining.
// Reset (rst, synchronous) empties the chain and clears count and overflow flag.
module stable_integer_argsort_top
  import sias_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key
  input  logic        s_tlast,   // last_key
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] sorted_key, [37:32] source_position, pad zeros
  output logic        m_tlast,   // final_rank
  output logic        m_tuser    // overflowed
);

  sias_state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             overflow, overflow_next;

  sias_ctl_t   ctl;
  sias_entry_t new_ent;
  sias_entry_t ent      [MAX_ITEMS];
  logic        greater  [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] valid_vec;

  logic accept_in;
  logic full;
  logic out_take;

  // The chain is full once its tail cell holds a key.
  assign full      = ent[MAX_ITEMS-1].valid;
  assign accept_in = s_tvalid && s_tready;
  assign out_take  = m_tvalid && m_tready;

  // Key narrowed/extended to the stored width, tagged with its load position.
  assign new_ent.valid = 1'b1;
  assign new_ent.key   = KEY_WIDTH'($signed(s_tdata));
  assign new_ent.pos   = POS_W'(count);

  assign ctl.ins   = accept_in && !full;
  assign ctl.shift = out_take;

  // Chain of cells: each takes from its left neighbor on insert, its right on drain.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    sias_entry_t prev_e;
    sias_entry_t next_e;
    logic        prev_g;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_e = ent[i-1];
      assign prev_g = greater[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ent[i+1];
    end

    sias_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .new_ent      (new_ent),
      .prev_ent     (prev_e),
      .prev_greater (prev_g),
      .next_ent     (next_e),
      .ent          (ent[i]),
      .greater      (greater[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  // Head cell feeds the result port directly.
  assign m_tdata = {2'b00, ent[0].pos, FIELD_KEY_W'(ent[0].key)};
  assign m_tlast = !ent[1].valid;
  assign m_tuser = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (accept_in) begin
          // Drop keys past capacity, but remember it for the run.
          if (full) begin
            overflow_next = 1'b1;
          end else begin
            count_next = count + CNT_W'(1);
          end
          if (s_tlast) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        m_tvalid = 1'b1;
        if (out_take && m_tlast) begin
          state_next    = ST_LOAD;
          count_next    = '0;
          overflow_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Occupied cells always form a contiguous run from the head.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + MAX_ITEMS'(1))) == '0)
    else $error("chain has a gap");

  // The count holds during drain while the chain empties, so check it while loading.
  a_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> $countones(valid_vec) == int'(count))
    else $error("load count disagrees with chain occupancy");

  a_drain_head: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> ent[0].valid)
    else $error("draining with empty head cell");

  a_run_empty: assert property (@(posedge clk) disable iff (rst)
    (out_take && m_tlast) |=> (valid_vec == '0 && !overflow))
    else $error("chain not empty after final result");

endmodule

// File: tb/stable_integer_argsort_checker.sv
`timescale 1ns / 100ps
// Checker for the stable argsort block: predicts each sorted run and compares the results.
module stable_integer_argsort_checker
  import sias_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key
  input  logic        s_tlast,   // last_key
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] sorted_key, [37:32] source_position, pad zeros
  input  logic        m_tlast,   // final_rank
  input  logic        m_tuser,   // overflowed
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic signed [FIELD_KEY_W-1:0] sorted_key;
    logic        [POS_W-1:0]       source_position;
    logic                          final_rank;
    logic                          overflowed;
  } ranked_key_t;

  logic signed [FIELD_KEY_W-1:0] key_mem [MAX_ITEMS];
  int          load_count = 0;
  logic        dropped = 1'b0;
  ranked_key_t ranked_q [$];
  int          err_count = 0;

  assign mismatches = err_count;

  task automatic report(input string field, input longint exp_v, input longint act_v);
    $error("%s: expected %0d, got %0d", field, exp_v, act_v);
    err_count++;
  endtask

  always @(posedge clk) begin
    int          rank [MAX_ITEMS];
    int          cur;
    int          i;
    ranked_key_t want;
    if (rst) begin
      load_count = 0;
      dropped    = 1'b0;
      ranked_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        // Keys past capacity are lost but mark the run.
        if (load_count < MAX_ITEMS) begin
          // Keep only the stored key width, sign-extended to the result field.
          key_mem[load_count] = FIELD_KEY_W'($signed(s_tdata[KEY_WIDTH-1:0]));
          load_count++;
        end else begin
          dropped = 1'b1;
        end
        if (s_tlast) begin
          for (int j = 0; j < load_count; j++) rank[j] = j;
          // Move only past strictly greater keys so that ties keep load order.
          for (int j = 1; j < load_count; j++) begin
            cur = rank[j];
            i   = j;
            while (i > 0 && key_mem[rank[i-1]] > key_mem[cur]) begin
              rank[i] = rank[i-1];
              i--;
            end
            rank[i] = cur;
          end
          for (int m = 0; m < load_count; m++) begin
            want.sorted_key      = key_mem[rank[m]];
            want.source_position = rank[m][POS_W-1:0];
            want.final_rank      = (m == load_count - 1);
            want.overflowed      = dropped;
            ranked_q.push_back(want);
          end
          load_count = 0;
          dropped    = 1'b0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (ranked_q.size() == 0) begin
          $error("unexpected result: key %0d position %0d",
                 $signed(m_tdata[31:0]), m_tdata[37:32]);
          err_count++;
        end else begin
          want = ranked_q.pop_front();
          if (m_tdata[31:0] !== want.sorted_key)
            report("sorted_key", want.sorted_key, $signed(m_tdata[31:0]));
          if (m_tdata[37:32] !== want.source_position)
            report("source_position", want.source_position, m_tdata[37:32]);
          if (m_tlast !== want.final_rank)
            report("final_rank", want.final_rank, m_tlast);
          if (m_tuser !== want.overflowed)
            report("overflowed", want.overflowed, m_tuser);
        end
      end
    end
    pending <= ranked_q.size();
  end

endmodule

// File: tb/stable_integer_argsort_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the stable argsort block: stimulus, flow control and verdict.
module stable_integer_argsort_top_tb;

  // Slowest correct run stays far below this; hitting it means a hang.
  localparam int LIMIT       = 200000;
  // Long receiver hold-off so that a full list backs up the input.
  localparam int HOLD_CYCLES = 400;
  // Settle time after the last result.
  localparam int TAIL_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] key
  logic        s_tlast = 1'b0; // last_key
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;        // [31:0] sorted_key, [37:32] source_position, pad zeros
  logic        m_tlast;        // final_rank
  logic        m_tuser;        // overflowed

  int   mismatches;
  int   pending;
  int   cycle_count = 0;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  logic hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stable_integer_argsort_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  stable_integer_argsort_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Watchdog: abort the run if it never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off on request.
  initial begin
    int hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (rx_calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 35);
      end
    end
  end

  // Offer one key request with random idle cycles ahead of it; return once accepted.
  task automatic send_key(input logic [31:0] k, input logic lst);
    if (!tx_calm) begin
      while ($urandom_range(99) < 35) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= k;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has been taken.
  task automatic drain_all();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Directed lists as {last, key}: a single maximum key, extremes with ties,
  // a strictly descending list and an all-equal list.
  logic [32:0] directed [18] = '{
    {1'b1, 32'h7FFF_FFFF},
    {1'b0, 32'h8000_0000}, {1'b0, 32'h7FFF_FFFF}, {1'b0, 32'h0000_0000},
    {1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h0000_0001}, {1'b0, 32'h0000_0005},
    {1'b0, 32'h0000_0005}, {1'b0, 32'h8000_0000}, {1'b0, 32'h7FFF_FFFF},
    {1'b1, 32'h0000_0005},
    {1'b0, 32'h0000_0003}, {1'b0, 32'h0000_0002}, {1'b0, 32'h0000_0001},
    {1'b1, 32'h0000_0000},
    {1'b0, 32'hFFFF_FFF9}, {1'b0, 32'hFFFF_FFF9}, {1'b1, 32'hFFFF_FFF9}
  };

  initial begin
    int          sent;
    int          len;
    int          style;
    int          list_no;
    logic [31:0] k;
    sent    = 0;
    list_no = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int d = 0; d < 18; d++) send_key(directed[d][31:0], directed[d][32]);
    drain_all();

    // Random lists: mostly short, some at or past capacity to force drops,
    // including one where the closing key itself is dropped.
    while (sent < 450) begin
      if (list_no == 2) begin
        len = 64;
        hold_req <= 1'b1;
      end else if (list_no == 5) begin
        len = 65;
      end else if ($urandom_range(11) == 0) begin
        len = $urandom_range(56, 70);
      end else begin
        len = $urandom_range(1, 12);
      end
      tx_calm = (list_no >= 10 && list_no < 16);
      rx_calm <= (list_no >= 10 && list_no < 16);
      style = $urandom_range(3);
      for (int j = 0; j < len; j++) begin
        case (style)
          2:       k = $urandom_range(6) - 3;
          3:       case ($urandom_range(3))
                     0:       k = 32'h8000_0000;
                     1:       k = 32'h7FFF_FFFF;
                     2:       k = 32'h0000_0000;
                     default: k = 32'hFFFF_FFFF;
                   endcase
          default: k = $urandom();
        endcase
        send_key(k, j == len - 1);
        sent++;
      end
      // Pause the sender now and then until the run has fully drained; keep
      // offering after the full list so that the held-off drain stalls the input.
      if (list_no != 2 && (list_no == 0 || $urandom_range(4) == 0)) drain_all();
      list_no++;
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sias_pkg.sv
rtl/core/sias_cell.sv
rtl/core/stable_integer_argsort_top.sv
tb/stable_integer_argsort_checker.sv
tb/stable_integer_argsort_top_tb.sv
